// ===== hw/rtl/lef_pkg.sv =====
`timescale 1ns / 1ps

package lef_pkg;

    localparam int HDR_LEN    = 18;
    localparam int CRC_LEN    = 4;
    localparam int Q_DEPTH    = 4;
    localparam int CNT_W      = $clog2(HDR_LEN);
    localparam int IDX_W      = 2;
    localparam int S_DATA_W   = 136;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAGIC  = 2'd1;
    localparam logic [IDX_W-1:0] REG_START  = 2'd2;

    // input opcodes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    typedef enum logic {
        K_HEAD,
        K_DATA
    } t_kind;

    typedef enum logic {
        BK_RUN,
        BK_TAIL
    } t_bk_state;

    // one queued command: a whole header or one payload byte
    typedef struct packed {
        t_kind       kind;
        logic        last;     // trailer follows this command
        logic [31:0] len;
        logic [31:0] src;
        logic [63:0] ts;
        logic [7:0]  data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hw/rtl/lef_cmd_q.sv =====
`timescale 1ns / 1ps

module lef_cmd_q #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lef_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output lef_pkg::t_cmd    o_cmd,
    output lef_pkg::t_q_status o_status
);
    import lef_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_cmd          = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/lef_front.sv =====
`timescale 1ns / 1ps

module lef_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [lef_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_enable,
    input  logic [63:0]                    i_start_time,
    input  lef_pkg::t_q_status             i_q_status,
    output logic                           o_push,
    output lef_pkg::t_cmd                  o_cmd
);
    import lef_pkg::*;

    logic        r_open, n_open;
    logic [31:0] r_left, n_left;
    logic        accept;
    logic [31:0] f_len, f_src;
    logic [63:0] f_now;
    logic [7:0]  f_byte;

    assign f_len  = i_s_tdata[31:0];
    assign f_src  = i_s_tdata[63:32];
    assign f_now  = i_s_tdata[127:64];
    assign f_byte = i_s_tdata[135:128];

    assign o_s_tready = !i_q_status.full;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_open     = r_open;
        n_left     = r_left;
        o_push     = 1'b0;
        o_cmd.kind = (i_s_tuser == OP_HEADER) ? K_HEAD : K_DATA;
        o_cmd.last = 1'b0;
        o_cmd.len  = f_len;
        o_cmd.src  = f_src;
        o_cmd.ts   = f_now - i_start_time;
        o_cmd.data = f_byte;
        if (accept && i_enable) begin
            if (i_s_tuser == OP_HEADER) begin
                // headers while payload is owed are dropped
                if (!r_open) begin
                    o_push     = 1'b1;
                    o_cmd.last = (f_len == '0);
                    if (f_len != '0) begin
                        n_open = 1'b1;
                        n_left = f_len;
                    end
                end
            end else if (r_open) begin
                o_push     = 1'b1;
                o_cmd.last = (r_left == 32'd1);
                n_left     = r_left - 1'b1;
                if (r_left == 32'd1) begin
                    n_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

// ===== hw/rtl/lef_back.sv =====
`timescale 1ns / 1ps

module lef_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_magic,
    input  lef_pkg::t_cmd       i_cmd,
    input  lef_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast
);
    import lef_pkg::*;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'h0, b & BYTE_MASK};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    t_bk_state        r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_crc, n_crc;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic             adv;
    logic [7:0]       hdr_b [HDR_LEN];
    logic [7:0]       cur_byte;
    logic [31:0]      crc_in;
    logic [31:0]      crc_out;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    // output slot free or being drained this cycle
    assign adv = !r_out_valid || i_m_tready;

    always_comb begin
        hdr_b[0] = i_magic[15:8];
        hdr_b[1] = i_magic[7:0];
        for (int i = 0; i < 4; i++) begin
            hdr_b[2 + i] = i_cmd.len[31 - 8 * i -: 8];
            hdr_b[6 + i] = i_cmd.src[31 - 8 * i -: 8];
        end
        for (int i = 0; i < 8; i++) begin
            hdr_b[10 + i] = i_cmd.ts[63 - 8 * i -: 8];
        end
    end

    assign cur_byte = (i_cmd.kind == K_HEAD) ? hdr_b[r_cnt] : i_cmd.data;
    assign crc_in   = (i_cmd.kind == K_HEAD && r_cnt == '0) ? 32'hFFFFFFFF : r_crc;
    assign crc_out  = ~r_crc;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        if (adv) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            BK_RUN: begin
                if (adv && !i_q_status.empty) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = cur_byte;
                    n_out_last  = 1'b0;
                    n_crc       = crc_byte(crc_in, cur_byte);
                    if (i_cmd.kind == K_DATA || r_cnt == CNT_W'(HDR_LEN - 1)) begin
                        o_pop = 1'b1;
                        n_cnt = '0;
                        if (i_cmd.last) begin
                            n_state = BK_TAIL;
                        end
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            BK_TAIL: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = crc_out[31 - 8 * r_cnt[1:0] -: 8];
                    n_out_last  = (r_cnt == CNT_W'(CRC_LEN - 1));
                    if (r_cnt == CNT_W'(CRC_LEN - 1)) begin
                        n_cnt   = '0;
                        n_state = BK_RUN;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc      <= n_crc;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

// ===== hw/rtl/log_entry_framer_crc32.sv =====
`timescale 1ns / 1ps

// Channel   | Dir | Beat moves
// ----------+-----+-------------------------------------------------------
// s (item)  | in  | tuser: opcode; tdata: length, source id, time, byte
// m (byte)  | out | tdata: record byte; tlast: final CRC byte of record
// cfg       | in  | index + 64-bit data; 0 enable, 1 magic, 2 start time
//
// A header beat becomes 18 output bytes (22 with a zero length), a payload
// beat one (five on the last byte); the back-end serializer emits them.
// Input beats are taken every cycle while the command queue has room.
// Reset is synchronous, active low; no record is open afterwards.
// A stalled output holds the byte; the front keeps filling the queue.

module log_entry_framer_crc32 #(
    parameter int QUEUE_DEPTH = lef_pkg::Q_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [31:0] payload_length, [63:32] source_id, [127:64] now_time,
    // [135:128] data_byte
    input  logic [lef_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] opcode
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] out_byte
    output logic [7:0]                    o_m_tdata,
    output logic                          o_m_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lef_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);
    import lef_pkg::*;

    logic        r_enable;
    logic [15:0] r_magic;
    logic [63:0] r_start;
    logic        push, pop;
    t_cmd        cmd_in, cmd_out;
    t_q_status   q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_magic  <= '0;
            r_start  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE: r_enable <= i_cfg_data[0];
                REG_MAGIC:  r_magic  <= i_cfg_data[15:0];
                REG_START:  r_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lef_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_enable     (r_enable),
        .i_start_time (r_start),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_cmd        (cmd_in)
    );

    lef_cmd_q #(
        .DEPTH (QUEUE_DEPTH)
    ) u_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd_in),
        .i_pop    (pop),
        .o_cmd    (cmd_out),
        .o_status (q_status)
    );

    lef_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_magic    (r_magic),
        .i_cmd      (cmd_out),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
